// ===== src/assert_macros.svh =====
// Shared assertion macros for the step detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset.
`define ATSD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("atsd assertion failed");

// Antecedent implies consequent in the same cycle.
`define ATSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("atsd assertion failed");

// Antecedent implies consequent in the next cycle.
`define ATSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("atsd assertion failed");

`endif

// ===== src/atsd_pkg.sv =====
package atsd_pkg;

	// Field widths
	localparam int SAMPLE_W  = 16;
	localparam int CFG_W     = 16;
	localparam int GAP_W     = 16;
	localparam int COUNT_W   = 24;
	localparam int DIST_W    = 23;
	localparam int CFG_IDX_W = 1;

	localparam int WINDOW_SIZE_DEF = 16;

	localparam logic [COUNT_W-1:0] STEP_MAX = {COUNT_W{1'b1}};
	localparam logic [GAP_W-1:0]   GAP_MAX  = {GAP_W{1'b1}};

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'd1;

	localparam logic [CFG_W-1:0] SCALE_RESET  = 16'd4000;
	localparam logic [CFG_W-1:0] OFFSET_RESET = 16'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_item;
		logic update_sum;
		logic latch_mean;
		logic start_thr;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

// ===== src/atsd_ram.sv =====
module atsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/atsd_div.sv =====
module atsd_div #(
	parameter int W = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [W:0]    shifted;
	logic [W+1:0]  diff;
	logic          borrow;

	// One restoring step: shift in the next dividend bit and trial subtract
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = {1'b0, shifted} - {2'b00, dvs_q};
		borrow  = diff[W+1];
	end

	// Control: count down one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= borrow ? shifted[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~borrow};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== src/atsd_ctrl.sv =====
`include "assert_macros.svh"

module atsd_ctrl import atsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_MEAN   = 5'b00100,
		ST_DTHR   = 5'b01000,
		ST_DECIDE = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Sequence one transaction through the datapath
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_READ;
				end
			end
			ST_READ: begin
				cmd.update_sum = 1'b1;
				state_d        = ST_MEAN;
			end
			ST_MEAN: begin
				cmd.latch_mean = 1'b1;
				cmd.start_thr  = 1'b1;
				state_d        = ST_DTHR;
			end
			ST_DTHR: begin
				if (!sts.div_busy) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	`ATSD_ASSERT_NXT(a_accept_reads, clk, arst_n, in_valid && !in_stall, state_q == ST_READ)
	`ATSD_ASSERT_NXT(a_decide_holds, clk, arst_n, (state_q == ST_DECIDE) && !sts.out_free, state_q == ST_DECIDE)

endmodule

// ===== src/atsd_dp.sv =====
`include "assert_macros.svh"

module atsd_dp import atsd_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic signed [SAMPLE_W-1:0] accel_z,
	input  logic                       clear_counts,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic                       step_detected,
	output logic [COUNT_W-1:0]         step_count,
	output logic [DIST_W-1:0]          distance,
	output logic signed [SAMPLE_W-1:0] mean_z,
	input  cmd_t                       cmd,
	output sts_t                       sts
);

	localparam int PW         = $clog2(WINDOW_SIZE);
	localparam int SUM_W      = SAMPLE_W + PW;
	localparam int LAST       = WINDOW_SIZE - 1;
	localparam int MEAN_SHIFT = SUM_W + PW;
	localparam int PROD_W     = 2 * SUM_W + 1;
	// Rounded-up reciprocal of the window size, exact for any SUM_W-bit magnitude
	localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(((64'd1 << MEAN_SHIFT)
		+ 64'(WINDOW_SIZE - 1)) / 64'(WINDOW_SIZE));

	// Configuration
	logic [CFG_W-1:0] scale_q;
	logic [CFG_W-1:0] offset_q;

	// Item and detector state
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       clear_q;
	logic [PW-1:0]              wptr_q;
	logic                       wrapped_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] peak_q;
	logic                       seeded_q;
	logic [GAP_W-1:0]           gap_q;
	logic [COUNT_W-1:0]         count_q;
	logic [DIST_W-1:0]          dist_q;
	logic [2:0]                 rem5_q;
	logic signed [SAMPLE_W-1:0] mean_q;

	// Output register
	logic                       out_valid_q;
	logic                       step_q;
	logic [COUNT_W-1:0]         count_out_q;
	logic [DIST_W-1:0]          dist_out_q;
	logic signed [SAMPLE_W-1:0] mean_out_q;

	logic [SAMPLE_W-1:0] ram_rdata;
	logic [SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]    sum_mag;
	logic [PROD_W-1:0]   mean_prod;
	logic [CFG_W-1:0]    div_quo;
	logic                div_busy;
	logic [SAMPLE_W:0]   qm;
	logic [SAMPLE_W:0]   qs;
	logic [GAP_W:0]      thr;
	logic signed [SAMPLE_W+1:0] peak_drop;
	logic                step;
	logic                count_inc;
	logic [COUNT_W-1:0]  count_next;
	logic [DIST_W-1:0]   dist_next;
	logic [2:0]          rem5_next;
	logic [3:0]          rem5_sum;
	logic signed [SAMPLE_W-1:0] peak_next;
	logic [GAP_W-1:0]    gap_next;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE:  scale_q  <= cfg_data;
				REG_OFFSET: offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window store
	atsd_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW_SIZE)
	) u_window (
		.clk   (clk),
		.we    (cmd.update_sum),
		.waddr (wptr_q),
		.wdata (sample_q),
		.re    (cmd.load_item),
		.raddr (wptr_q),
		.rdata (ram_rdata)
	);

	// Slots read as zero until the pointer has wrapped once
	assign old_sample = wrapped_q ? ram_rdata : '0;

	// Average: scale the magnitude by the reciprocal, then restore the sign
	// (truncation toward zero)
	always_comb begin
		sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		mean_prod = PROD_W'(sum_mag) * PROD_W'(RECIP);
		qm        = mean_prod[MEAN_SHIFT +: SAMPLE_W + 1];
		qs        = sum_q[SUM_W-1] ? (~qm + 1'b1) : qm;
	end

	// Serial divider for the threshold quotient
	atsd_div #(
		.W(CFG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_thr),
		.dividend (scale_q),
		.divisor  (gap_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Threshold compare and next state of the detector
	always_comb begin
		thr       = {1'b0, div_quo} + {1'b0, offset_q};
		peak_drop = {{2{peak_q[SAMPLE_W-1]}}, peak_q} - {{2{mean_q[SAMPLE_W-1]}}, mean_q};
		step      = peak_drop >= $signed({1'b0, thr});
		count_inc = step && (count_q != STEP_MAX);
		count_next = count_inc ? count_q + 1'b1 : count_q;
		rem5_sum  = {1'b0, rem5_q} + 4'd2;
		if (!count_inc) begin
			rem5_next = rem5_q;
			dist_next = dist_q;
		end else if (rem5_sum >= 4'd5) begin
			rem5_next = 3'(rem5_sum - 4'd5);
			dist_next = dist_q + 1'b1;
		end else begin
			rem5_next = rem5_sum[2:0];
			dist_next = dist_q;
		end
		if (step) begin
			peak_next = mean_q;
			gap_next  = GAP_W'(1);
		end else begin
			peak_next = (mean_q > peak_q) ? mean_q : peak_q;
			gap_next  = (gap_q != GAP_MAX) ? gap_q + 1'b1 : gap_q;
		end
	end

	// Hold the sample of the current transaction
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			sample_q <= accel_z;
			clear_q  <= clear_counts;
		end
		if (cmd.latch_mean) begin
			mean_q <= qs[SAMPLE_W-1:0];
		end
	end

	// Detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
			peak_q    <= '0;
			seeded_q  <= 1'b0;
			gap_q     <= GAP_W'(1);
			count_q   <= '0;
			dist_q    <= '0;
			rem5_q    <= '0;
		end else if (cmd.update_sum) begin
			sum_q <= sum_q - {{PW{old_sample[SAMPLE_W-1]}}, old_sample}
				+ {{PW{sample_q[SAMPLE_W-1]}}, sample_q};
			if (wptr_q == PW'(LAST)) begin
				wptr_q    <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (!seeded_q) begin
				peak_q   <= sample_q;
				seeded_q <= 1'b1;
			end
			if (clear_q) begin
				count_q <= '0;
				dist_q  <= '0;
				rem5_q  <= '0;
			end
		end else if (cmd.commit) begin
			count_q <= count_next;
			dist_q  <= dist_next;
			rem5_q  <= rem5_next;
			peak_q  <= peak_next;
			gap_q   <= gap_next;
		end
	end

	// Output register: load on commit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			step_q      <= step;
			count_out_q <= count_next;
			dist_out_q  <= dist_next;
			mean_out_q  <= mean_q;
		end
	end

	assign sts.div_busy  = div_busy;
	assign sts.out_free  = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign step_detected = step_q;
	assign step_count    = count_out_q;
	assign distance      = dist_out_q;
	assign mean_z        = mean_out_q;

	`ATSD_ASSERT(a_rem5_range, clk, arst_n, rem5_q < 3'd5)
	`ATSD_ASSERT(a_gap_nonzero, clk, arst_n, gap_q != '0)
	`ATSD_ASSERT_IMP(a_commit_ready, clk, arst_n, cmd.commit, sts.out_free && !div_busy)

endmodule

// ===== src/adaptive_threshold_step_detector.sv =====
// Peak-drop step detector: each accepted transaction carries one vertical
// acceleration sample, which enters a moving-average window of WINDOW_SIZE
// entries; a step counts when the largest average since the last step has
// fallen by threshold_scale / gap + threshold_offset, and every transaction
// returns one result with the step flag, the saturating step count, the
// distance floor(count * 2 / 5) and the current average. One transaction
// at a time is processed: the next one is taken once the result of the
// last has been committed. The average comes from a combinational
// reciprocal multiplication; the bit-serial divider forms the threshold.
// The result sits in an output register, so a new transaction is accepted
// while the previous result still waits to be taken; the following result
// then waits at its decide step until that register frees up. Write the two
// configuration registers only while the block is idle.
module adaptive_threshold_step_detector import atsd_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] accel_z,
	input  logic                       clear_counts,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       step_detected,
	output logic [COUNT_W-1:0]         step_count,
	output logic [DIST_W-1:0]          distance,
	output logic signed [SAMPLE_W-1:0] mean_z
);

	cmd_t cmd;
	sts_t sts;

	atsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	atsd_dp #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accel_z       (accel_z),
		.clear_counts  (clear_counts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.step_detected (step_detected),
		.step_count    (step_count),
		.distance      (distance),
		.mean_z        (mean_z),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	import atsd_pkg::*;

	localparam int WIN_LEN     = WINDOW_SIZE_DEF;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;

	// One result of the detector
	typedef struct packed {
		logic                       step;
		logic [COUNT_W-1:0]         count;
		logic [DIST_W-1:0]          dist_val;
		logic signed [SAMPLE_W-1:0] mean;
	} step_report_t;

	// One directed row; rows with has_known carry a hand-derived result
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] z;
		logic                       clr;
		logic                       has_known;
		step_report_t               known;
	} sample_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] accel_z;
	logic                       clear_counts;
	logic                       out_valid;
	logic                       out_stall;
	logic                       step_detected;
	logic [COUNT_W-1:0]         step_count;
	logic [DIST_W-1:0]          distance;
	logic signed [SAMPLE_W-1:0] mean_z;

	adaptive_threshold_step_detector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.accel_z      (accel_z),
		.clear_counts (clear_counts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.step_detected(step_detected),
		.step_count   (step_count),
		.distance     (distance),
		.mean_z       (mean_z)
	);

	// Detector state mirrored by the predictor
	logic [CFG_W-1:0] cfg_scale;
	logic [CFG_W-1:0] cfg_offset;
	int               win_samples [WIN_LEN];
	int               win_ptr;
	int               win_total;
	int               peak_avg;
	int               gap_len;
	int               step_total;
	bit               peak_loaded;

	step_report_t pending_reports[$];
	step_report_t oldest_report;

	bit tx_idle;
	bit rx_idle;
	bit rx_hold_req;
	int fails;
	int samples_sent;
	int reports_seen;
	int steps_seen;
	int in_blocked;
	int settings_used;
	int cycle_count;

	// Pulse-train shaping state for the random samples
	int seg_left;
	bit seg_noise;
	bit seg_high;
	int seg_level;

	// Directed rows: after reset, full-scale swings, truncation of a
	// negative sum, clear with a step, alternating bit patterns
	sample_row_t directed_rows [0:21] = '{
		'{16'sd0,      1'b0, 1'b1, '{1'b0, 24'd0, 23'd0, 16'sd0}},
		'{16'sh7FFF,   1'b0, 1'b1, '{1'b0, 24'd0, 23'd0, 16'sd2047}},
		'{16'sh8000,   1'b0, 1'b1, '{1'b1, 24'd1, 23'd0, 16'sd0}},
		'{16'sh7FFF,   1'b0, 1'b0, '0},
		'{16'sh7FFF,   1'b0, 1'b0, '0},
		'{16'sh7FFF,   1'b0, 1'b0, '0},
		'{16'sh8000,   1'b1, 1'b0, '0},
		'{16'sh8000,   1'b0, 1'b0, '0},
		'{16'sh8000,   1'b0, 1'b0, '0},
		'{-16'sd1,     1'b0, 1'b0, '0},
		'{16'sd1,      1'b0, 1'b0, '0},
		'{16'sh5555,   1'b0, 1'b0, '0},
		'{16'shAAAA,   1'b0, 1'b0, '0},
		'{16'sd0,      1'b1, 1'b0, '0},
		'{16'sh7FFF,   1'b0, 1'b0, '0},
		'{16'sh8000,   1'b0, 1'b0, '0},
		'{16'sh7FFF,   1'b1, 1'b0, '0},
		'{16'sh8000,   1'b0, 1'b0, '0},
		'{-16'sd2,     1'b0, 1'b0, '0},
		'{16'sd16384,  1'b0, 1'b0, '0},
		'{-16'sd16384, 1'b1, 1'b0, '0},
		'{16'sd0,      1'b0, 1'b0, '0}
	};

	// Work out the result of one sample and advance the mirrored state
	function automatic step_report_t predict_step(input logic signed [SAMPLE_W-1:0] z,
			input logic clr);
		int           avg;
		int           thr;
		int           gap;
		step_report_t r;
		r = '0;
		if (clr) begin
			step_total = 0;
		end
		if (!peak_loaded) begin
			peak_avg    = z;
			peak_loaded = 1'b1;
		end
		win_total            = win_total - win_samples[win_ptr] + z;
		win_samples[win_ptr] = z;
		win_ptr              = (win_ptr + 1) % WIN_LEN;
		// Signed division truncates toward zero
		avg = win_total / WIN_LEN;
		gap = (gap_len == 0) ? 1 : gap_len;
		thr = int'(cfg_scale) / gap + int'(cfg_offset);
		if (peak_avg - avg >= thr) begin
			r.step = 1'b1;
			if (step_total < int'(STEP_MAX)) begin
				step_total++;
			end
			peak_avg = avg;
			gap_len  = 1;
		end else begin
			if (avg > peak_avg) begin
				peak_avg = avg;
			end
			if (gap_len < int'(GAP_MAX)) begin
				gap_len++;
			end
		end
		r.count    = step_total[COUNT_W-1:0];
		r.dist_val = DIST_W'(step_total * 2 / 5);
		r.mean     = avg[SAMPLE_W-1:0];
		return r;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("run timed out after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

	// Result side: draw a stall per transaction, or hold off for a long stretch on request
	initial begin
		int wait_cycles;
		int held;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_stall <= 1'b1;
				held = 0;
				while (held < LONG_HOLD) begin
					@(negedge clk);
					held++;
				end
				rx_hold_req = 1'b0;
			end else begin
				wait_cycles = rx_idle ? $urandom_range(0, 9) : 0;
				if (wait_cycles > 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall)) begin
				@(posedge clk);
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			reports_seen++;
			if (step_detected === 1'b1) begin
				steps_seen++;
			end
			if (pending_reports.size() == 0) begin
				$error("result with nothing expected: step %b count %0d", step_detected,
					step_count);
				fails++;
			end else begin
				oldest_report = pending_reports.pop_front();
				if (step_detected !== oldest_report.step) begin
					$error("step_detected: expected %b, got %b", oldest_report.step,
						step_detected);
					fails++;
				end
				if (step_count !== oldest_report.count) begin
					$error("step_count: expected %0d, got %0d", oldest_report.count, step_count);
					fails++;
				end
				if (distance !== oldest_report.dist_val) begin
					$error("distance: expected %0d, got %0d", oldest_report.dist_val, distance);
					fails++;
				end
				if (mean_z !== oldest_report.mean) begin
					$error("mean_z: expected %0d, got %0d", oldest_report.mean, mean_z);
					fails++;
				end
			end
		end
	end

	// Offer one sample, hold it until accepted, then queue its expected result
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] z, input logic clr,
			input logic has_known, input step_report_t known);
		int           gap;
		step_report_t guess;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		accel_z      <= z;
		clear_counts <= clr;
		@(posedge clk);
		while (in_stall) begin
			in_blocked++;
			@(posedge clk);
		end
		guess = predict_step(z, clr);
		pending_reports.push_back(has_known ? known : guess);
		samples_sent++;
	endtask

	// Next random sample: mostly alternating high and low plateaus with a little
	// jitter, so the average swings through peaks; otherwise full-range noise
	task automatic next_sample(output logic signed [SAMPLE_W-1:0] z, output logic clr);
		int v;
		if (seg_left == 0) begin
			seg_noise = ($urandom_range(0, 3) == 0);
			seg_left  = seg_noise ? $urandom_range(1, 6) : $urandom_range(3, 20);
			seg_high  = !seg_high;
			seg_level = seg_high ? int'($urandom_range(0, 32767))
				: -int'($urandom_range(0, 32768));
		end
		seg_left--;
		if (seg_noise) begin
			v = int'($urandom_range(0, 65535)) - 32768;
		end else begin
			v = seg_level + int'($urandom_range(0, 800)) - 400;
		end
		if (v > 32767) begin
			v = 32767;
		end else if (v < -32768) begin
			v = -32768;
		end
		z   = v[SAMPLE_W-1:0];
		clr = ($urandom_range(0, 19) == 0);
	endtask

	// Send a run of random samples; request the long hold-off at one of them
	task automatic run_samples(input int n, input int hold_at);
		logic signed [SAMPLE_W-1:0] z;
		logic                       clr;
		for (int k = 0; k < n; k++) begin
			if (k == hold_at) begin
				rx_hold_req = 1'b1;
			end
			next_sample(z, clr);
			send_sample(z, clr, 1'b0, '0);
		end
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Write both threshold registers while the block is idle
	task automatic set_thresholds(input logic [CFG_W-1:0] scale, input logic [CFG_W-1:0] offset);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SCALE;
		cfg_data  <= scale;
		@(negedge clk);
		cfg_index <= REG_OFFSET;
		cfg_data  <= offset;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cfg_scale  = scale;
		cfg_offset = offset;
		settings_used++;
	endtask

	// Main sequence
	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_SCALE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		accel_z      = '0;
		clear_counts = 1'b0;
		tx_idle      = 1'b1;
		rx_idle      = 1'b1;
		rx_hold_req  = 1'b0;
		fails         = 0;
		samples_sent  = 0;
		reports_seen  = 0;
		steps_seen    = 0;
		in_blocked    = 0;
		settings_used = 1;
		seg_left      = 0;
		seg_noise     = 1'b0;
		seg_high      = 1'b0;
		seg_level     = 0;
		// Mirror the reset state
		for (int k = 0; k < WIN_LEN; k++) begin
			win_samples[k] = 0;
		end
		win_ptr     = 0;
		win_total   = 0;
		peak_avg    = 0;
		gap_len     = 1;
		step_total  = 0;
		peak_loaded = 1'b0;
		cfg_scale   = SCALE_RESET;
		cfg_offset  = OFFSET_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset thresholds: directed rows, then random with the long hold-off
		foreach (directed_rows[i]) begin
			send_sample(directed_rows[i].z, directed_rows[i].clr, directed_rows[i].has_known,
				directed_rows[i].known);
		end
		run_samples(100, 30);
		drain;

		// Zero threshold: a step whenever the average does not rise
		set_thresholds('0, '0);
		run_samples(60, -1);
		drain;

		// Largest threshold: no step can count
		set_thresholds('1, '1);
		run_samples(60, -1);
		drain;

		// Largest scale alone, then largest offset alone
		set_thresholds('1, '0);
		run_samples(60, -1);
		drain;
		set_thresholds('0, '1);
		run_samples(30, -1);
		drain;

		// Moderate random thresholds with no idling on either side
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		set_thresholds(CFG_W'($urandom_range(0, 8000)), CFG_W'($urandom_range(0, 3000)));
		run_samples(80, -1);
		drain;
		tx_idle = 1'b1;
		rx_idle = 1'b1;

		// Back to the reset values
		set_thresholds(SCALE_RESET, OFFSET_RESET);
		run_samples(60, -1);
		drain;

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d expected results never arrived", pending_reports.size());
			fails++;
		end
		$display("Run: %0d samples under %0d threshold settings, %0d results, %0d steps",
			samples_sent, settings_used, reports_seen, steps_seen);
		$display("Input held off for %0d cycles; %0d mismatches", in_blocked, fails);
		if (fails == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
